// File: hdl/hyp_pkg.sv
// ----------------------------------------------------------------------------
// hyp_pkg: shared types and floating-point helpers
// Unpacking, rounding and power-of-two scaling of single-precision words,
// used by the front stages and the back stages of the vector magnitude core.
// ----------------------------------------------------------------------------
`default_nettype none

package hyp_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
    localparam int          ROOT_CELLS = 26;

    // Pre-scaling class picked from the larger operand's exponent.
    typedef enum logic [1:0] {
        SC_HIGH,
        SC_DIRECT,
        SC_LOW,
        SC_DENORM
    } scale_t;

    // Normalized operand: value = mant / 2^23 * 2^exp, mant[23] set.
    typedef struct packed {
        logic [23:0]        mant;
        logic signed [11:0] exp;
    } unp_t;

    // Item that travels down the square-root cell row.
    typedef struct packed {
        logic [49:0] rem;
        logic [50:0] res;
        logic [7:0]  be;
        scale_t      sc;
        logic        nan;
        logic        zero;
        logic        inf;
    } root_t;

    // Power of two applied to the operands for each class.
    function automatic logic signed [11:0] scale_shift(scale_t sc);
        logic signed [11:0] s;
        case (sc)
            SC_HIGH:   s = -12'sd64;
            SC_DIRECT: s = 12'sd0;
            SC_LOW:    s = 12'sd64;
            SC_DENORM: s = 12'sd87;
            default:   s = 12'sd0;
        endcase
        return s;
    endfunction

    // Split a finite nonzero word into a normalized mantissa and exponent.
    function automatic unp_t unpack(logic [31:0] b);
        unp_t       u;
        logic [4:0] lz;
        logic       found;
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 22; i >= 0; i--) begin
            if (!found && b[i]) begin
                lz    = 5'(22 - i);
                found = 1'b1;
            end
        end
        if (b[30:23] != 8'd0) begin
            u.mant = {1'b1, b[22:0]};
            u.exp  = $signed({4'b0, b[30:23]}) - 12'sd127;
        end
        else begin
            u.mant = {1'b0, b[22:0]} << (lz + 5'd1);
            u.exp  = 12'sd0 - 12'sd127 - $signed({7'b0, lz});
        end
        return u;
    endfunction

    // Round to nearest even and pack. m is normalized with its top bit set,
    // value = m / 2^49 * 2^exp, st_in holds any bits below m.
    function automatic logic [31:0] round_pack(logic [49:0] m, logic signed [11:0] exp,
                                               logic st_in);
        logic signed [11:0] be;
        logic signed [11:0] bef;
        logic [5:0]         sh;
        logic [49:0]        ms;
        logic [49:0]        mask;
        logic               lost;
        logic               g;
        logic               st;
        logic [23:0]        kept;
        logic [24:0]        q;
        logic [31:0]        r;
        be = exp + 12'sd127;
        if (be < 12'sd1) begin
            if (be < -12'sd50) begin
                sh = 6'd52;
            end
            else begin
                sh = 6'(12'sd1 - be);
            end
        end
        else begin
            sh = 6'd0;
        end
        mask = ~({50{1'b1}} << sh);
        lost = |(m & mask);
        ms   = m >> sh;
        kept = ms[49:26];
        g    = ms[25];
        st   = (|ms[24:0]) | lost | st_in;
        q    = {1'b0, kept} + {24'd0, g & (st | kept[0])};
        if (be < 12'sd1) begin
            // Subnormal result; a carry into bit 23 makes it the smallest normal.
            r = {1'b0, 7'd0, q[23], q[22:0]};
        end
        else begin
            bef = be + $signed({11'b0, q[24]});
            if (bef >= 12'sd255) begin
                r = INF_BITS;
            end
            else begin
                r = {1'b0, bef[7:0], (q[24] ? 23'd0 : q[22:0])};
            end
        end
        return r;
    endfunction

    // Multiply a nonnegative word by 2^sh with rounding.
    function automatic logic [31:0] scale_bits(logic [31:0] b, logic signed [11:0] sh);
        unp_t        u;
        logic [31:0] r;
        u = unpack(b);
        if (b[30:0] == 31'd0) begin
            r = 32'd0;
        end
        else if (b[30:23] == 8'hFF) begin
            r = INF_BITS;
        end
        else begin
            r = round_pack({u.mant, 26'd0}, u.exp + sh, 1'b0);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hyp_front.sv
// ----------------------------------------------------------------------------
// hyp_front: scaling, squaring and summing stages
// Six pipeline stages: operand scaling, mantissa squares, square rounding,
// aligned add, sum rounding and preparation of the square-root radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module hyp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [31:0]    x_bits,
    input  wire logic [31:0]    y_bits,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hyp_pkg::root_t      out_item
);

    logic [5:0] v_reg;
    logic [5:0] v_next;
    logic [5:0] en;

    // Stage 1 registers
    logic [31:0]      ax_reg, ay_reg, ax_next, ay_next;
    hyp_pkg::scale_t  sc1_reg, sc1_next;
    logic             nan1_reg, nan1_next;
    // Stage 2 registers
    logic [47:0]        px_reg, py_reg, px_next, py_next;
    logic signed [11:0] ex_reg, ey_reg, ex_next, ey_next;
    logic               zx_reg, zy_reg, ix_reg, iy_reg;
    logic               zx_next, zy_next, ix_next, iy_next;
    hyp_pkg::scale_t    sc2_reg;
    logic               nan2_reg;
    // Stage 3 registers
    logic [31:0]      sx_reg, sy_reg, sx_next, sy_next;
    hyp_pkg::scale_t  sc3_reg;
    logic             nan3_reg;
    // Stage 4 registers
    logic               dir_reg, dir_next;
    logic [31:0]        dbits_reg, dbits_next;
    logic [50:0]        sum_reg, sum_next;
    logic signed [11:0] sexp_reg, sexp_next;
    logic               lost_reg, lost_next;
    hyp_pkg::scale_t    sc4_reg;
    logic               nan4_reg;
    // Stage 5 registers
    logic [31:0]      s_reg, s_next;
    hyp_pkg::scale_t  sc5_reg;
    logic             nan5_reg;
    // Stage 6 register
    hyp_pkg::root_t   root_reg, root_next;

    // Each stage loads when it is empty or its successor moves on.
    always_comb
    begin
        en[5] = !v_reg[5] || out_ready;
        for (int k = 4; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k + 1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < 6; k++) begin
            v_next[k] = en[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[5];
    assign out_item  = root_reg;

    // Stage 1: NaN check, scaling class and operand pre-scaling.
    always_comb
    begin
        logic [31:0] xa;
        logic [31:0] ya;
        logic [31:0] mx;
        logic [7:0]  e;
        xa        = {1'b0, x_bits[30:0]};
        ya        = {1'b0, y_bits[30:0]};
        nan1_next = (xa > hyp_pkg::INF_BITS) || (ya > hyp_pkg::INF_BITS);
        mx        = (xa > ya) ? xa : ya;
        e         = mx[30:23];
        if (e >= 8'd191) begin
            sc1_next = hyp_pkg::SC_HIGH;
        end
        else if (e > 8'd75) begin
            sc1_next = hyp_pkg::SC_DIRECT;
        end
        else if (e == 8'd0) begin
            sc1_next = hyp_pkg::SC_DENORM;
        end
        else begin
            sc1_next = hyp_pkg::SC_LOW;
        end
        ax_next = hyp_pkg::scale_bits(xa, hyp_pkg::scale_shift(sc1_next));
        ay_next = hyp_pkg::scale_bits(ya, hyp_pkg::scale_shift(sc1_next));
    end

    // Stage 2: mantissa squares.
    always_comb
    begin
        hyp_pkg::unp_t ux;
        hyp_pkg::unp_t uy;
        ux      = hyp_pkg::unpack(ax_reg);
        uy      = hyp_pkg::unpack(ay_reg);
        px_next = ux.mant * ux.mant;
        py_next = uy.mant * uy.mant;
        ex_next = ux.exp <<< 1;
        ey_next = uy.exp <<< 1;
        zx_next = (ax_reg[30:0] == 31'd0);
        zy_next = (ay_reg[30:0] == 31'd0);
        ix_next = (ax_reg[30:23] == 8'hFF);
        iy_next = (ay_reg[30:23] == 8'hFF);
    end

    // Stage 3: round the squares.
    always_comb
    begin
        if (zx_reg) begin
            sx_next = 32'd0;
        end
        else if (ix_reg) begin
            sx_next = hyp_pkg::INF_BITS;
        end
        else if (px_reg[47]) begin
            sx_next = hyp_pkg::round_pack({px_reg, 2'b0}, ex_reg + 12'sd1, 1'b0);
        end
        else begin
            sx_next = hyp_pkg::round_pack({px_reg[46:0], 3'b0}, ex_reg, 1'b0);
        end
        if (zy_reg) begin
            sy_next = 32'd0;
        end
        else if (iy_reg) begin
            sy_next = hyp_pkg::INF_BITS;
        end
        else if (py_reg[47]) begin
            sy_next = hyp_pkg::round_pack({py_reg, 2'b0}, ey_reg + 12'sd1, 1'b0);
        end
        else begin
            sy_next = hyp_pkg::round_pack({py_reg[46:0], 3'b0}, ey_reg, 1'b0);
        end
    end

    // Stage 4: align the smaller square and add.
    always_comb
    begin
        logic [31:0]        big;
        logic [31:0]        sml;
        hyp_pkg::unp_t      ub;
        hyp_pkg::unp_t      us;
        logic signed [11:0] d;
        logic [5:0]         dcap;
        logic [50:0]        bfull;
        big = (sx_reg >= sy_reg) ? sx_reg : sy_reg;
        sml = (sx_reg >= sy_reg) ? sy_reg : sx_reg;
        ub  = hyp_pkg::unpack(big);
        us  = hyp_pkg::unpack(sml);
        d   = ub.exp - us.exp;
        dcap = (d > 12'sd63) ? 6'd63 : d[5:0];
        bfull = {1'b0, us.mant, 26'd0};
        lost_next = |(bfull & ~({51{1'b1}} << dcap));
        sum_next  = {1'b0, ub.mant, 26'd0} + (bfull >> dcap);
        sexp_next = ub.exp;
        // Infinity or a zero addend passes the larger word through unchanged.
        dir_next   = (big[30:23] == 8'hFF) || (sml[30:0] == 31'd0);
        dbits_next = big;
    end

    // Stage 5: round the sum.
    always_comb
    begin
        if (dir_reg) begin
            s_next = dbits_reg;
        end
        else if (sum_reg[50]) begin
            s_next = hyp_pkg::round_pack(sum_reg[50:1], sexp_reg + 12'sd1,
                                         lost_reg | sum_reg[0]);
        end
        else begin
            s_next = hyp_pkg::round_pack(sum_reg[49:0], sexp_reg, lost_reg);
        end
    end

    // Stage 6: radicand with an even exponent and the result exponent.
    always_comb
    begin
        hyp_pkg::unp_t      us;
        logic signed [11:0] k;
        logic signed [11:0] k2;
        logic signed [11:0] kh;
        logic signed [11:0] be12;
        logic [25:0]        m26;
        us = hyp_pkg::unpack(s_reg);
        k  = us.exp - 12'sd23;
        if (k[0]) begin
            m26 = {1'b0, us.mant, 1'b0};
            k2  = k - 12'sd1;
        end
        else begin
            m26 = {us.mant, 2'b0};
            k2  = k - 12'sd2;
        end
        kh   = ((k2 - 12'sd24) >>> 1) + 12'sd1;
        be12 = kh + 12'sd150;
        root_next.rem  = {m26, 24'd0};
        root_next.res  = 51'd0;
        root_next.be   = be12[7:0];
        root_next.sc   = sc5_reg;
        root_next.nan  = nan5_reg;
        root_next.zero = (s_reg[30:0] == 31'd0);
        root_next.inf  = (s_reg[30:23] == 8'hFF);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 6'd0;
        end
        else begin
            v_reg <= v_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            sc1_reg  <= sc1_next;
            nan1_reg <= nan1_next;
        end
        if (en[1]) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            zx_reg   <= zx_next;
            zy_reg   <= zy_next;
            ix_reg   <= ix_next;
            iy_reg   <= iy_next;
            sc2_reg  <= sc1_reg;
            nan2_reg <= nan1_reg;
        end
        if (en[2]) begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            sc3_reg  <= sc2_reg;
            nan3_reg <= nan2_reg;
        end
        if (en[3]) begin
            dir_reg   <= dir_next;
            dbits_reg <= dbits_next;
            sum_reg   <= sum_next;
            sexp_reg  <= sexp_next;
            lost_reg  <= lost_next;
            sc4_reg   <= sc3_reg;
            nan4_reg  <= nan3_reg;
        end
        if (en[4]) begin
            s_reg    <= s_next;
            sc5_reg  <= sc4_reg;
            nan5_reg <= nan4_reg;
        end
        if (en[5]) begin
            root_reg <= root_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hyp_cell.sv
// ----------------------------------------------------------------------------
// hyp_cell: one digit step of the integer square root
// Holds one item of the root row, tries one result bit and hands the
// partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hyp_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [5:0]     bit_pos,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hyp_pkg::root_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hyp_pkg::root_t      out_item
);

    logic           v_reg;
    hyp_pkg::root_t item_reg;
    hyp_pkg::root_t item_next;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_item  = item_reg;

    // Trial subtract of the current root plus this cell's bit.
    always_comb
    begin
        logic [50:0] bitv;
        logic [50:0] trial;
        bitv      = 51'd1 << bit_pos;
        trial     = in_item.res + bitv;
        item_next = in_item;
        if ({1'b0, in_item.rem} >= trial) begin
            item_next.rem = in_item.rem - trial[49:0];
            item_next.res = (in_item.res >> 1) + bitv;
        end
        else begin
            item_next.res = in_item.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end
        else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hyp_back.sv
// ----------------------------------------------------------------------------
// hyp_back: root rounding and result scaling
// Rounds the integer root to a single, then applies the inverse power of
// two and holds the finished item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hyp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hyp_pkg::root_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         out_bits
);

    logic [1:0]       v_reg;
    logic [1:0]       en;
    logic [31:0]      r_reg, r_next;
    hyp_pkg::scale_t  sc_reg;
    logic             nan_reg;
    logic [31:0]      o_reg, o_next;

    assign en[1]     = !v_reg[1] || out_ready;
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];
    assign out_bits  = o_reg;

    // Round the 25-bit root to 24 bits, nearest even with the remainder as sticky.
    always_comb
    begin
        logic [23:0] q;
        logic [24:0] q25;
        logic [23:0] mant;
        logic [8:0]  be9;
        logic        inc;
        q    = in_item.res[24:1];
        inc  = in_item.res[0] & ((in_item.rem != 50'd0) | q[0]);
        q25  = {1'b0, q} + {24'd0, inc};
        mant = q25[24] ? q25[24:1] : q25[23:0];
        be9  = {1'b0, in_item.be} + {8'd0, q25[24]};
        if (in_item.inf) begin
            r_next = hyp_pkg::INF_BITS;
        end
        else if (in_item.zero) begin
            r_next = 32'd0;
        end
        else begin
            r_next = {1'b0, be9[7:0], mant[22:0]};
        end
    end

    // Undo the operand scaling.
    always_comb
    begin
        if (nan_reg) begin
            o_next = hyp_pkg::QNAN_BITS;
        end
        else begin
            o_next = hyp_pkg::scale_bits(r_reg, 12'sd0 - hyp_pkg::scale_shift(sc_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 2'd0;
        end
        else begin
            if (en[0]) begin
                v_reg[0] <= in_valid;
            end
            if (en[1]) begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            r_reg   <= r_next;
            sc_reg  <= in_item.sc;
            nan_reg <= in_item.nan;
        end
        if (en[1]) begin
            o_reg <= o_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/float_hypot_scaled_core.sv
// Pipeline: 6 front stages, 26 square-root cells and 2 back stages lie
// between an accepted item and its result. Throughput: one item per cycle
// while the output is not stalled; each stage holds one item and moves on
// when its successor has room, so bubbles close up behind a stalled output.
// Reset: rst_n clears every stage's valid flag; payload registers keep no reset.
// ----------------------------------------------------------------------------
// float_hypot_scaled_core: single-precision vector magnitude
// Computes sqrt(x*x + y*y) with operand pre-scaling by a power of two,
// each operation rounded to nearest even; NaN operands give a quiet NaN.
// ----------------------------------------------------------------------------
`default_nettype none

module float_hypot_scaled_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [31:0]    x_bits,
    input  wire logic [31:0]    y_bits,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         magnitude_bits
);

    logic           front_ready;
    logic           chain_valid [0:hyp_pkg::ROOT_CELLS];
    logic           chain_ready [0:hyp_pkg::ROOT_CELLS];
    hyp_pkg::root_t chain_item  [0:hyp_pkg::ROOT_CELLS];

    assign in_stall = !front_ready;

    // Scaling, squares and sum.
    hyp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .x_bits    (x_bits),
        .y_bits    (y_bits),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    // Row of root cells, one result bit per cell from the top down.
    for (genvar j = 0; j < hyp_pkg::ROOT_CELLS; j++) begin : g_cell
        hyp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bit_pos   (6'(2 * (hyp_pkg::ROOT_CELLS - 1 - j))),
            .in_valid  (chain_valid[j]),
            .in_ready  (chain_ready[j]),
            .in_item   (chain_item[j]),
            .out_valid (chain_valid[j + 1]),
            .out_ready (chain_ready[j + 1]),
            .out_item  (chain_item[j + 1])
        );
    end

    // Rounding, result scaling and output register.
    hyp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[hyp_pkg::ROOT_CELLS]),
        .in_ready  (chain_ready[hyp_pkg::ROOT_CELLS]),
        .in_item   (chain_item[hyp_pkg::ROOT_CELLS]),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_bits  (magnitude_bits)
    );

endmodule

`default_nettype wire

// File: hdl/hyp_checker.sv
// ----------------------------------------------------------------------------
// hyp_checker: port-level checks for the vector magnitude core
// Output hold under stall and the form of every delivered result.
// ----------------------------------------------------------------------------
`default_nettype none

module hyp_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           out_valid,
    input  wire logic           out_stall,
    input  wire logic [31:0]    magnitude_bits
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_hold_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(magnitude_bits))
        else $error("result changed while stalled");

    // A magnitude is never negative.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !magnitude_bits[31])
        else $error("negative magnitude");

    // Every NaN result is the canonical quiet NaN.
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && magnitude_bits[30:23] == 8'hFF && magnitude_bits[22:0] != 23'd0
        |-> magnitude_bits == hyp_pkg::QNAN_BITS)
        else $error("non-canonical NaN result");

endmodule

bind float_hypot_scaled_core hyp_checker u_hyp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .magnitude_bits (magnitude_bits)
);

`default_nettype wire
